[hw/rtl/catmod_pkg.sv]
// Package for the Catalan-modulo-prime unit: prime constants, widths and the
// request/response structs of the shared modular multiplier.
// No dependencies.
`default_nettype none

package catmod_pkg;

  // Residue width and prime
  localparam int RES_W  = 20;
  localparam int PROD_W = 2 * RES_W;
  localparam logic [RES_W-1:0] PRIME  = 20'd1000003;
  // Fermat exponent for inversion
  localparam logic [RES_W-1:0] EXP_P2 = PRIME - 20'd2;
  // 2^20 mod p; a fold replaces hi*2^20 by hi*FOLD_C
  localparam int FOLD_W = 16;
  localparam logic [FOLD_W-1:0] FOLD_C = 16'd48573;
  // Six folds bring any product below 2p
  localparam int FOLDS   = 6;
  // Multiply stage, fold stages, final subtract
  localparam int MUL_LAT = FOLDS + 2;
  localparam int LANE_W  = $clog2(MUL_LAT + 1);
  localparam int BIT_W   = $clog2(RES_W);

  localparam int INDEX_BITS_DEF = 20;

  typedef struct packed {
    logic             vld;
    logic [RES_W-1:0] a;
    logic [RES_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             vld;
    logic [RES_W-1:0] value;
  } mul_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/catmod_modmul.sv]
// Pipelined multiplier modulo 1000003: one 20x20 product, six constant folds,
// one conditional subtract. Accepts one operation per cycle.
// Depends on catmod_pkg.
`default_nettype none

module catmod_modmul (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire catmod_pkg::mul_req_t req,
  output catmod_pkg::mul_rsp_t     rsp
);

  localparam int RES_W  = catmod_pkg::RES_W;
  localparam int PROD_W = catmod_pkg::PROD_W;
  localparam int FOLDS  = catmod_pkg::FOLDS;

  logic [PROD_W-1:0] stg_r   [FOLDS+1];
  logic [PROD_W-1:0] fold_w  [FOLDS];
  logic [FOLDS:0]    vld_r;
  logic              res_vld_r;
  logic [RES_W-1:0]  res_r;
  logic [RES_W:0]    red_w;
  logic [RES_W:0]    sub_w;

  // Fold: x = hi*2^20 + lo  ->  hi*FOLD_C + lo
  for (genvar j = 0; j < FOLDS; j++) begin : g_fold
    assign fold_w[j] = PROD_W'(stg_r[j][PROD_W-1:RES_W]) * PROD_W'(catmod_pkg::FOLD_C)
                     + PROD_W'(stg_r[j][RES_W-1:0]);
  end

  assign red_w = stg_r[FOLDS][RES_W:0];
  assign sub_w = red_w - {1'b0, catmod_pkg::PRIME};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      res_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[FOLDS-1:0], req.vld};
      res_vld_r <= vld_r[FOLDS];
    end
    stg_r[0] <= PROD_W'(req.a) * PROD_W'(req.b);
    for (int j = 0; j < FOLDS; j++) begin
      stg_r[j+1] <= fold_w[j];
    end
    res_r <= (red_w >= {1'b0, catmod_pkg::PRIME}) ? sub_w[RES_W-1:0] : red_w[RES_W-1:0];
  end

  assign rsp.vld   = res_vld_r;
  assign rsp.value = res_r;

endmodule

`default_nettype wire

[hw/rtl/catalan_mod_prime_unit.sv]
// Catalan number C(k) modulo 1000003, built on one shared pipelined modular
// multiplier. Depends on catmod_pkg and catmod_modmul.
//
// One transaction in, one transaction out. For index k of 0 or 1 the result
// is 1; once 2k reaches 1000003 the result is 0; both skip the multiplier and
// go straight to S_DONE. Otherwise C(k) = B / k! with B = (k+2)*...*(2k):
// the unit forms k! and then B by streaming one factor per cycle into the
// 8-stage multiplier, with the stage outputs fed back as up to 8 interleaved
// partial products that are merged once the range is done. k! is inverted
// by left-to-right square-and-multiply with exponent p-2 (28 dependent
// multiplies), and one last multiply gives the result. in_stall stays high
// from accept until the result has been moved into the output register; a
// new transaction may be accepted while that result still waits on out_stall.
`default_nettype none

module catalan_mod_prime_unit #(
  parameter int INDEX_BITS = catmod_pkg::INDEX_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [INDEX_BITS-1:0]         in_index_k,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [catmod_pkg::RES_W-1:0]       out_catalan_value
);

  localparam int RES_W  = catmod_pkg::RES_W;
  localparam int LANE_W = catmod_pkg::LANE_W;
  localparam int BIT_W  = catmod_pkg::BIT_W;
  // Compare width: holds 2k and the prime
  localparam int CW = (INDEX_BITS + 1 > RES_W + 1) ? INDEX_BITS + 1 : RES_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RANGE,
    S_MERGE,
    S_EXP_ISSUE,
    S_EXP_WAIT,
    S_FIN_ISSUE,
    S_FIN_WAIT,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [RES_W-1:0]     k_r, k_nxt;
  logic [RES_W-1:0]     i_r, i_nxt;
  logic [RES_W-1:0]     end_r, end_nxt;
  logic                 phase_r, phase_nxt;
  logic [RES_W-1:0]     m_r, m_nxt;
  logic                 mv_r, mv_nxt;
  logic [RES_W-1:0]     a_r, a_nxt;
  logic [RES_W-1:0]     b_r, b_nxt;
  logic [RES_W-1:0]     acc_r, acc_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic                 mstep_r, mstep_nxt;
  logic [RES_W-1:0]     res_r, res_nxt;
  logic [LANE_W-1:0]    inflight_r, inflight_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]     out_value_r, out_value_nxt;

  logic [CW-1:0]        k_ext;
  logic [CW-1:0]        k_dbl;
  logic                 k_small;
  logic                 k_big;

  catmod_pkg::mul_req_t req;
  catmod_pkg::mul_rsp_t rsp;

  catmod_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Classify the incoming index
  assign k_ext   = CW'(in_index_k);
  assign k_dbl   = k_ext << 1;
  assign k_small = (in_index_k <= INDEX_BITS'(1));
  assign k_big   = (k_dbl >= CW'(catmod_pkg::PRIME));

  assign inflight_nxt = inflight_r + LANE_W'(req.vld) - LANE_W'(rsp.vld);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    end_nxt       = end_r;
    phase_nxt     = phase_r;
    m_nxt         = m_r;
    mv_nxt        = mv_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    bit_nxt       = bit_r;
    mstep_nxt     = mstep_r;
    res_nxt       = res_r;
    // hold the result while stalled, drop it once taken
    out_valid_nxt = out_valid_r & out_stall;
    out_value_nxt = out_value_r;
    req           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          k_nxt = k_ext[RES_W-1:0];
          if (k_small) begin
            res_nxt   = RES_W'(1);
            state_nxt = S_DONE;
          end else if (k_big) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            // first range: 1 .. k
            i_nxt     = RES_W'(1);
            end_nxt   = k_ext[RES_W-1:0];
            phase_nxt = 1'b0;
            state_nxt = S_RANGE;
          end
        end
      end

      S_RANGE: begin
        // feed one factor per cycle; returning lanes carry their partial product
        req.vld = 1'b1;
        req.a   = rsp.vld ? rsp.value : RES_W'(1);
        req.b   = i_r;
        i_nxt   = i_r + RES_W'(1);
        if (i_r == end_r) begin
          mv_nxt    = 1'b0;
          state_nxt = S_MERGE;
        end
      end

      S_MERGE: begin
        // pair up lanes as they come out until one value is left
        if (rsp.vld) begin
          if (mv_r) begin
            req.vld = 1'b1;
            req.a   = m_r;
            req.b   = rsp.value;
            mv_nxt  = 1'b0;
          end else begin
            m_nxt  = rsp.value;
            mv_nxt = 1'b1;
          end
        end else if (inflight_r == '0 && mv_r) begin
          mv_nxt = 1'b0;
          if (!phase_r) begin
            // k! done; second range: k+2 .. 2k
            a_nxt     = m_r;
            phase_nxt = 1'b1;
            i_nxt     = k_r + RES_W'(2);
            end_nxt   = {k_r[RES_W-2:0], 1'b0};
            state_nxt = S_RANGE;
          end else begin
            b_nxt     = m_r;
            acc_nxt   = RES_W'(1);
            bit_nxt   = BIT_W'(RES_W - 1);
            mstep_nxt = 1'b0;
            state_nxt = S_EXP_ISSUE;
          end
        end
      end

      S_EXP_ISSUE: begin
        req.vld   = 1'b1;
        req.a     = acc_r;
        req.b     = mstep_r ? a_r : acc_r;
        state_nxt = S_EXP_WAIT;
      end

      S_EXP_WAIT: begin
        if (rsp.vld) begin
          acc_nxt = rsp.value;
          if (!mstep_r && catmod_pkg::EXP_P2[bit_r]) begin
            mstep_nxt = 1'b1;
            state_nxt = S_EXP_ISSUE;
          end else if (bit_r == '0) begin
            state_nxt = S_FIN_ISSUE;
          end else begin
            bit_nxt   = bit_r - BIT_W'(1);
            mstep_nxt = 1'b0;
            state_nxt = S_EXP_ISSUE;
          end
        end
      end

      S_FIN_ISSUE: begin
        // B times the inverse of k!
        req.vld   = 1'b1;
        req.a     = b_r;
        req.b     = acc_r;
        state_nxt = S_FIN_WAIT;
      end

      S_FIN_WAIT: begin
        if (rsp.vld) begin
          res_nxt   = rsp.value;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // advance into the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inflight_r  <= '0;
      out_valid_r <= 1'b0;
      mv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inflight_r  <= inflight_nxt;
      out_valid_r <= out_valid_nxt;
      mv_r        <= mv_nxt;
    end
    k_r         <= k_nxt;
    i_r         <= i_nxt;
    end_r       <= end_nxt;
    phase_r     <= phase_nxt;
    m_r         <= m_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    acc_r       <= acc_nxt;
    bit_r       <= bit_nxt;
    mstep_r     <= mstep_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_catalan_value = out_value_r;

`ifndef ASSERT_OFF
  // Never more operations in flight than multiplier stages
  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= LANE_W'(catmod_pkg::MUL_LAT))
    else $error("multiplier in-flight count exceeds pipeline depth");

  // No multiplier result may arrive while idle
  a_no_stray_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.vld |-> (state_r != S_IDLE))
    else $error("multiplier result arrived while idle");

  // An accepted transaction always starts work
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start");

  // Every result is a reduced residue
  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_value_r < catmod_pkg::PRIME))
    else $error("result not reduced modulo the prime");
`endif

endmodule

`default_nettype wire

[dv/catalan_checker.sv]
`timescale 1ns / 1ps
// Checker for catalan_mod_prime_unit: watches both channels, predicts the
// Catalan number modulo 1000003 for each accepted index and compares results.
// Depends on catmod_pkg.

module catalan_checker #(
  parameter int INDEX_BITS = catmod_pkg::INDEX_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [INDEX_BITS-1:0]       in_index_k,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [catmod_pkg::RES_W-1:0] out_catalan_value,
  output int                               mismatches,
  output int                               outstanding
);

  localparam int RES_W = catmod_pkg::RES_W;

  typedef struct {
    logic [INDEX_BITS-1:0] index;
    logic [RES_W-1:0]      value;
  } catalan_due_t;

  catalan_due_t catalan_due[$];
  int           fail_cnt = 0;
  int           due_cnt  = 0;

  assign mismatches  = fail_cnt;
  assign outstanding = due_cnt;

  function automatic longint unsigned fermat_pow(input longint unsigned base,
                                                 input longint unsigned ex);
    longint unsigned acc;
    longint unsigned b;
    longint unsigned e;
    acc = 1;
    b   = base % catmod_pkg::PRIME;
    e   = ex;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % catmod_pkg::PRIME;
      b = (b * b) % catmod_pkg::PRIME;
      e = e >> 1;
    end
    return acc;
  endfunction

  // C(k) = (2k)! / (k! (k+1)!) mod p; zero once (2k)! picks up p as a factor
  function automatic logic [RES_W-1:0] catalan_mod(input logic [INDEX_BITS-1:0] idx);
    longint unsigned k;
    longint unsigned fact;
    longint unsigned fact_k;
    longint unsigned fact_k1;
    longint unsigned res;
    k = idx;
    if (k <= 1) return RES_W'(1);
    if (2 * k >= catmod_pkg::PRIME) return '0;
    fact    = 1;
    fact_k  = 1;
    fact_k1 = 1;
    for (longint unsigned i = 1; i <= 2 * k; i++) begin
      fact = (fact * i) % catmod_pkg::PRIME;
      if (i == k) fact_k = fact;
      if (i == k + 1) fact_k1 = fact;
    end
    res = (fact * fermat_pow(fact_k, catmod_pkg::EXP_P2)) % catmod_pkg::PRIME;
    res = (res * fermat_pow(fact_k1, catmod_pkg::EXP_P2)) % catmod_pkg::PRIME;
    return res[RES_W-1:0];
  endfunction

  always @(posedge clk) begin
    catalan_due_t head;
    if (rst_n) begin
      // check the result before queuing a new index: a result can never
      // belong to an index accepted at the same edge
      if (out_valid && !out_stall) begin
        if (catalan_due.size() == 0) begin
          fail_cnt++;
          $error("unexpected result catalan_value=%0d", out_catalan_value);
        end else begin
          head = catalan_due.pop_front();
          if (out_catalan_value !== head.value) begin
            fail_cnt++;
            $error("catalan_value (index %0d): expected %0d, actual %0d",
                   head.index, head.value, out_catalan_value);
          end
        end
      end
      if (in_valid && !in_stall)
        catalan_due.push_back('{in_index_k, catalan_mod(in_index_k)});
    end
    due_cnt = catalan_due.size();
  end

endmodule

[dv/tb_catalan_mod_prime_unit.sv]
`timescale 1ns / 1ps
// Top-level testbench for catalan_mod_prime_unit: drives indices and result
// back-pressure, instantiates the unit and catalan_checker, and gives the verdict.
// Depends on catmod_pkg, catalan_mod_prime_unit and catalan_checker.

module tb_catalan_mod_prime_unit;

  localparam int INDEX_BITS = catmod_pkg::INDEX_BITS_DEF;
  localparam int RES_W      = catmod_pkg::RES_W;
  // Largest single busy stretch is index 500001, with no transaction on either
  // channel during it. Allow several times that stretch.
  localparam int unsigned QUIET_LIMIT = 4_000_000;
  localparam int RANDOM_ITEMS = 100;
  // Trailing wait after the last result; unit latency head room
  localparam int TAIL_CYCLES = 400;
  localparam int NUM_DIRECTED = 16;

  // Directed indices: zero and one, small values, all-ones and top bit alone,
  // and both sides of the point where 2k reaches the prime
  localparam int unsigned DIRECTED [NUM_DIRECTED] = '{
    0, 1, 2, 3, 4, 7, 8, 15, 16, 100,
    500002, 500003, 999999, 524288, 1048575, 500001
  };

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [INDEX_BITS-1:0] in_index_k  = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [RES_W-1:0]      out_catalan_value;

  int          mismatch_count;
  int          pending_count;
  int          idle_pct     = 14;
  int unsigned quiet_cycles = 0;

  catalan_mod_prime_unit #(
    .INDEX_BITS (INDEX_BITS)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_index_k        (in_index_k),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_catalan_value (out_catalan_value)
  );

  catalan_checker #(
    .INDEX_BITS (INDEX_BITS)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_index_k        (in_index_k),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_catalan_value (out_catalan_value),
    .mismatches        (mismatch_count),
    .outstanding       (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random back-pressure on the result channel; idle_pct drops to zero
  // during the no-idle stretch
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Watchdog: end the run if no transaction moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** catalan_mod_prime_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one index and hold it until the unit takes it. Valid stays high
  // afterwards; the next call lowers it only if it idles first, so valid
  // never gets two updates in one step.
  task automatic send_index(input logic [INDEX_BITS-1:0] k);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_index_k <= k;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Hold off the sender until every predicted result has come back.
  // Poll on the falling edge so the checker's count is settled.
  task automatic drain_results;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  initial begin
    int unsigned           sel;
    logic [INDEX_BITS-1:0] k;

    // Hold the synchronous reset, then release it
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_index(DIRECTED[i][INDEX_BITS-1:0]);
    drain_results();

    // Mostly small indices to keep the run short; a few medium ones, and
    // large ones that take the zero path and exercise the upper bits
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_pct = (i >= 40 && i < 70) ? 0 : 14;
      if (i == 70) drain_results();
      sel = $urandom_range(99);
      if (sel < 55)
        k = INDEX_BITS'($urandom_range(300, 0));
      else if (sel < 75)
        k = INDEX_BITS'($urandom_range(3000, 301));
      else if (sel < 80)
        k = INDEX_BITS'($urandom_range(30000, 3001));
      else
        k = INDEX_BITS'($urandom_range(1048575, 500002));
      send_index(k);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("** catalan_mod_prime_unit: PASSED **");
    end else begin
      $display("** catalan_mod_prime_unit: FAILED **");
    end
    $finish;
  end

endmodule
